// ----- rtl/bson_element_stream_parser_unit_assert.svh -----
// Assertion macros for the BSON element stream parser.
`ifndef BSON_ELEMENT_STREAM_PARSER_UNIT_ASSERT_SVH
`define BSON_ELEMENT_STREAM_PARSER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Clocked check, off while reset is high.
`define BSEP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also holds through reset.
`define BSEP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BSEP_ASSERT(lbl, clk, rst, prop, msg)
`define BSEP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- rtl/bsep_pkg.sv -----
// Shared types and constants of the BSON element stream parser.
package bsep_pkg;

  localparam int NAME_MAX_BYTES = 32;
  localparam int NAME_CNT_W     = $clog2(NAME_MAX_BYTES + 1);

  localparam logic [7:0] BT_END    = 8'h00;
  localparam logic [7:0] BT_DOUBLE = 8'h01;
  localparam logic [7:0] BT_STRING = 8'h02;
  localparam logic [7:0] BT_BINARY = 8'h05;
  localparam logic [7:0] BT_BOOL   = 8'h08;
  localparam logic [7:0] BT_INT32  = 8'h10;
  localparam logic [7:0] BT_INT64  = 8'h12;
  localparam logic [7:0] BT_ERASED = 8'hff;

  typedef enum logic [2:0] {
    KIND_NAME    = 3'd0,
    KIND_NODE    = 3'd1,
    KIND_PAYLOAD = 3'd2,
    KIND_END     = 3'd3,
    KIND_ERROR   = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_TOO_LARGE   = 3'd1,
    ERR_PAST_BUFFER = 3'd2,
    ERR_ERASED      = 3'd3,
    ERR_NAME_LONG   = 3'd4,
    ERR_UNSUPPORTED = 3'd5
  } err_t;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         node_type;
    logic [4:0]         name_length;
    logic [7:0]         out_byte;
    logic [63:0]        value_bits;
    logic signed [31:0] payload_length;
    logic [7:0]         binary_subtype;
    logic               last_payload;
    err_t               error_code;
  } result_t;

endpackage

// ----- rtl/bsep_if.sv -----
// Stream channel interfaces: input byte beats and parser result beats.
interface bsep_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_document;

  modport source(output valid, data_byte, start_document, input ready);
  modport sink(input valid, data_byte, start_document, output ready);
endinterface

interface bsep_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic [7:0]         node_type;
  logic [4:0]         name_length;
  logic [7:0]         out_byte;
  logic [63:0]        value_bits;
  logic signed [31:0] payload_length;
  logic [7:0]         binary_subtype;
  logic               last_payload;
  logic [2:0]         error_code;

  modport source(output valid, kind, node_type, name_length, out_byte, value_bits,
                 payload_length, binary_subtype, last_payload, error_code,
                 input ready);
  modport sink(input valid, kind, node_type, name_length, out_byte, value_bits,
               payload_length, binary_subtype, last_payload, error_code,
               output ready);
endinterface

// ----- rtl/bsep_core.sv -----
// Parse state and per-byte step logic of the BSON element stream parser.
`include "bson_element_stream_parser_unit_assert.svh"

module bsep_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [7:0]        data_byte,
  input  logic              start_document,
  input  logic [31:0]       buffer_size,
  output logic              res_valid,
  output bsep_pkg::result_t res
);

  typedef enum logic [2:0] {
    PH_LEN     = 3'd0,
    PH_TYPE    = 3'd1,
    PH_NAME    = 3'd2,
    PH_VALUE   = 3'd3,
    PH_LENWORD = 3'd4,
    PH_SUBTYPE = 3'd5,
    PH_PAYLOAD = 3'd6
  } phase_t;

  phase_t                          phase, cur_phase, phase_next;
  logic [31:0]                     pos, cur_pos, pos_next;
  logic [31:0]                     lim, cur_lim, lim_next;
  logic [3:0]                      fcnt, cur_fcnt, fcnt_next;
  logic [63:0]                     acc, cur_acc, acc_next;
  logic [bsep_pkg::NAME_CNT_W-1:0] ncnt, cur_ncnt, ncnt_next;
  logic [7:0]                      ctype, cur_type, type_next;
  logic [31:0]                     pend, cur_pend, pend_next;
  logic                            dead, cur_dead, dead_next;
  logic                            done, cur_done, done_next;

  logic [3:0]         vsize;
  logic [31:0]        rd_size;
  logic               fits;
  logic [5:0]         shamt;
  logic [63:0]        acc_ins;
  logic [63:0]        acc_sub;
  logic [63:0]        fin_acc;
  logic [31:0]        word;
  logic [31:0]        lim_sel;
  logic signed [31:0] word_s;
  logic signed [31:0] lim_s;
  logic signed [31:0] fin_word_s;
  logic               fail;
  bsep_pkg::err_t     fail_code;

  // start_document clears everything before this byte is parsed
  always_comb begin
    if (start_document) begin
      cur_phase = PH_LEN;
      cur_pos   = '0;
      cur_lim   = '0;
      cur_fcnt  = '0;
      cur_acc   = '0;
      cur_ncnt  = '0;
      cur_type  = '0;
      cur_pend  = '0;
      cur_dead  = 1'b0;
      cur_done  = 1'b0;
    end else begin
      cur_phase = phase;
      cur_pos   = pos;
      cur_lim   = lim;
      cur_fcnt  = fcnt;
      cur_acc   = acc;
      cur_ncnt  = ncnt;
      cur_type  = ctype;
      cur_pend  = pend;
      cur_dead  = dead;
      cur_done  = done;
    end
  end

  always_comb begin
    if (cur_type == bsep_pkg::BT_DOUBLE || cur_type == bsep_pkg::BT_INT64) begin
      vsize = 4'd8;
    end else if (cur_type == bsep_pkg::BT_INT32) begin
      vsize = 4'd4;
    end else begin
      vsize = 4'd1;
    end
  end

  // one shared bounds check: size < limit and position + size <= limit
  always_comb begin
    unique case (cur_phase)
      PH_VALUE:   rd_size = {28'd0, vsize};
      PH_LENWORD: rd_size = 32'd4;
      PH_PAYLOAD: rd_size = cur_pend;
      default:    rd_size = 32'd1;
    endcase
    fits = (rd_size < cur_lim) && (({1'b0, cur_pos} + {1'b0, rd_size}) <= {1'b0, cur_lim});
  end

  always_comb begin
    if (cur_phase == PH_VALUE) begin
      shamt = {cur_fcnt[2:0], 3'b000};
    end else begin
      shamt = {1'b0, cur_fcnt[1:0], 3'b000};
    end
    acc_ins    = cur_acc | ({56'd0, data_byte} << shamt);
    acc_sub    = cur_acc | {24'd0, data_byte, 32'd0};
    word       = acc_ins[31:0];
    lim_sel    = (buffer_size != 32'd0) ? buffer_size : word;
    word_s     = $signed(word);
    lim_s      = $signed(lim_sel);
    fin_acc    = (cur_phase == PH_SUBTYPE) ? acc_sub : acc_ins;
    fin_word_s = $signed(fin_acc[31:0]);
  end

  always_comb begin
    phase_next = cur_phase;
    pos_next   = cur_pos;
    lim_next   = cur_lim;
    fcnt_next  = cur_fcnt;
    acc_next   = cur_acc;
    ncnt_next  = cur_ncnt;
    type_next  = cur_type;
    pend_next  = cur_pend;
    dead_next  = cur_dead;
    done_next  = cur_done;
    fail       = 1'b0;
    fail_code  = bsep_pkg::ERR_NONE;
    res_valid  = 1'b0;
    res        = '0;

    if (!cur_dead && !cur_done) begin
      unique case (cur_phase)
        PH_LEN: begin
          acc_next  = acc_ins;
          fcnt_next = cur_fcnt + 4'd1;
          pos_next  = cur_pos + 32'd1;
          if (cur_fcnt >= 4'd3) begin
            lim_next   = lim_sel;
            fcnt_next  = '0;
            acc_next   = '0;
            phase_next = PH_TYPE;
            if (lim_sel <= 32'd4) begin
              fail      = 1'b1;
              fail_code = bsep_pkg::ERR_PAST_BUFFER;
            end else if (word_s > 0 && word_s > lim_s) begin
              fail      = 1'b1;
              fail_code = bsep_pkg::ERR_TOO_LARGE;
            end
          end
        end
        PH_TYPE: begin
          if (!fits) begin
            fail      = 1'b1;
            fail_code = bsep_pkg::ERR_PAST_BUFFER;
          end else begin
            pos_next  = cur_pos + 32'd1;
            type_next = data_byte;
            ncnt_next = '0;
            acc_next  = '0;
            fcnt_next = '0;
            if (data_byte == bsep_pkg::BT_END) begin
              done_next = 1'b1;
              res_valid = 1'b1;
              res.kind  = bsep_pkg::KIND_END;
            end else if (data_byte == bsep_pkg::BT_ERASED) begin
              fail      = 1'b1;
              fail_code = bsep_pkg::ERR_ERASED;
            end else begin
              phase_next = PH_NAME;
            end
          end
        end
        PH_NAME: begin
          if (!fits) begin
            fail      = 1'b1;
            fail_code = bsep_pkg::ERR_PAST_BUFFER;
          end else begin
            pos_next = cur_pos + 32'd1;
            if (data_byte == 8'd0) begin
              if (cur_type == bsep_pkg::BT_DOUBLE || cur_type == bsep_pkg::BT_BOOL ||
                  cur_type == bsep_pkg::BT_INT32 || cur_type == bsep_pkg::BT_INT64) begin
                phase_next = PH_VALUE;
              end else if (cur_type == bsep_pkg::BT_STRING ||
                           cur_type == bsep_pkg::BT_BINARY) begin
                phase_next = PH_LENWORD;
              end else begin
                fail      = 1'b1;
                fail_code = bsep_pkg::ERR_UNSUPPORTED;
              end
            end else begin
              ncnt_next = cur_ncnt + 1'b1;
              if (ncnt_next >= bsep_pkg::NAME_CNT_W'(bsep_pkg::NAME_MAX_BYTES)) begin
                fail      = 1'b1;
                fail_code = bsep_pkg::ERR_NAME_LONG;
              end else begin
                res_valid    = 1'b1;
                res.kind     = bsep_pkg::KIND_NAME;
                res.out_byte = data_byte;
              end
            end
          end
        end
        PH_VALUE: begin
          if (cur_fcnt == 4'd0 && !fits) begin
            fail      = 1'b1;
            fail_code = bsep_pkg::ERR_PAST_BUFFER;
          end else begin
            acc_next  = acc_ins;
            fcnt_next = cur_fcnt + 4'd1;
            pos_next  = cur_pos + 32'd1;
            if (fcnt_next >= vsize) begin
              fcnt_next  = '0;
              phase_next = PH_TYPE;
              res_valid  = 1'b1;
              res.kind   = bsep_pkg::KIND_NODE;
              if (cur_type == bsep_pkg::BT_BOOL) begin
                res.value_bits = {63'd0, acc_ins != 64'd0};
              end else begin
                res.value_bits = acc_ins;
              end
            end
          end
        end
        PH_LENWORD, PH_SUBTYPE: begin
          if ((cur_phase == PH_SUBTYPE || cur_fcnt == 4'd0) && !fits) begin
            fail      = 1'b1;
            fail_code = bsep_pkg::ERR_PAST_BUFFER;
          end else begin
            pos_next = cur_pos + 32'd1;
            acc_next = fin_acc;
            if (cur_phase == PH_LENWORD) begin
              fcnt_next = cur_fcnt + 4'd1;
            end
            if (cur_phase == PH_LENWORD && cur_fcnt >= 4'd3 &&
                cur_type == bsep_pkg::BT_BINARY) begin
              fcnt_next  = '0;
              phase_next = PH_SUBTYPE;
            end else if (cur_phase == PH_SUBTYPE || cur_fcnt >= 4'd3) begin
              // length word complete: report node, then payload if positive
              pend_next          = (fin_word_s > 0) ? fin_acc[31:0] : 32'd0;
              fcnt_next          = '0;
              phase_next         = (pend_next != 32'd0) ? PH_PAYLOAD : PH_TYPE;
              res_valid          = 1'b1;
              res.kind           = bsep_pkg::KIND_NODE;
              res.payload_length = fin_word_s;
              res.binary_subtype = fin_acc[39:32];
            end
          end
        end
        PH_PAYLOAD: begin
          if (cur_fcnt == 4'd0 && !fits) begin
            fail      = 1'b1;
            fail_code = bsep_pkg::ERR_PAST_BUFFER;
          end else begin
            if (cur_fcnt == 4'd0) begin
              fcnt_next = 4'd1;
            end
            pos_next  = cur_pos + 32'd1;
            pend_next = (cur_pend != 32'd0) ? cur_pend - 32'd1 : 32'd0;
            if (pend_next == 32'd0) begin
              fcnt_next  = '0;
              phase_next = PH_TYPE;
            end
            res_valid          = 1'b1;
            res.kind           = bsep_pkg::KIND_PAYLOAD;
            res.out_byte       = data_byte;
            res.payload_length = $signed(cur_acc[31:0]);
            res.binary_subtype = cur_acc[39:32];
            res.last_payload   = (pend_next == 32'd0);
          end
        end
        default: begin
          phase_next = PH_TYPE;
        end
      endcase
    end

    if (fail) begin
      dead_next      = 1'b1;
      res_valid      = 1'b1;
      res            = '0;
      res.kind       = bsep_pkg::KIND_ERROR;
      res.error_code = fail_code;
    end
    if (res_valid) begin
      res.node_type   = type_next;
      res.name_length = 5'(ncnt_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_LEN;
      pos   <= '0;
      lim   <= '0;
      fcnt  <= '0;
      acc   <= '0;
      ncnt  <= '0;
      ctype <= '0;
      pend  <= '0;
      dead  <= 1'b0;
      done  <= 1'b0;
    end else if (fire) begin
      phase <= phase_next;
      pos   <= pos_next;
      lim   <= lim_next;
      fcnt  <= fcnt_next;
      acc   <= acc_next;
      ncnt  <= ncnt_next;
      ctype <= type_next;
      pend  <= pend_next;
      dead  <= dead_next;
      done  <= done_next;
    end
  end

  `BSEP_ASSERT(a_error_kills, clk, rst, fire && res_valid && res.kind == bsep_pkg::KIND_ERROR |=> dead, "error beat did not stop the parser")
  `BSEP_ASSERT(a_quiet_when_stopped, clk, rst, (dead || done) && !start_document |-> !res_valid, "result after document end or error")
  `BSEP_ASSERT_ALWAYS(a_err_code_match, clk, res_valid |-> ((res.kind == bsep_pkg::KIND_ERROR) == (res.error_code != bsep_pkg::ERR_NONE)), "error code and kind disagree")
  `BSEP_ASSERT(a_last_on_payload, clk, rst, res_valid && res.last_payload |-> res.kind == bsep_pkg::KIND_PAYLOAD, "last flag outside payload")
  `BSEP_ASSERT(a_end_sets_done, clk, rst, fire && res_valid && res.kind == bsep_pkg::KIND_END |=> done && !dead, "document end did not stop the parser")

endmodule

// ----- rtl/bsep_out_reg.sv -----
// Result register between the parse step and the output channel.
module bsep_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  bsep_pkg::result_t res,
  output logic              can_take,
  bsep_out_if.source        dout
);

  logic              valid;
  bsep_pkg::result_t res_q;

  assign can_take = !valid || dout.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (dout.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res;
    end
  end

  assign dout.valid          = valid;
  assign dout.kind           = res_q.kind;
  assign dout.node_type      = res_q.node_type;
  assign dout.name_length    = res_q.name_length;
  assign dout.out_byte       = res_q.out_byte;
  assign dout.value_bits     = res_q.value_bits;
  assign dout.payload_length = res_q.payload_length;
  assign dout.binary_subtype = res_q.binary_subtype;
  assign dout.last_payload   = res_q.last_payload;
  assign dout.error_code     = res_q.error_code;

endmodule

// ----- rtl/bson_element_stream_parser_unit.sv -----
// Top level of the BSON element stream parser: byte stream in, parse events out.
//
//   channel  dir  beat contents
//   -------  ---  ---------------------------------------------------------
//   din      in   data_byte, start_document (first length byte of a document)
//   dout     out  kind, node_type, name_length, out_byte, value_bits,
//                 payload_length, binary_subtype, last_payload, error_code
//   cfg      in   cfg_we / cfg_wdata: buffer_size, no read-back
//
// One byte per clock: each byte is parsed by the single step stage in
// bsep_core while it is offered, and its result (if any) is loaded into the
// output register in bsep_out_reg at the accepting edge, on dout next cycle.
// din.ready is low only while the output register holds a beat that dout
// has not taken; a byte that yields no result still needs that slot free.
// rst (synchronous) clears parse state, buffer_size and the output valid.
// buffer_size is sampled at the fourth length byte of each document.
module bson_element_stream_parser_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  bsep_in_if.sink     din,
  bsep_out_if.source  dout
);

  logic              [31:0] buffer_size;
  logic                     can_take;
  logic                     fire;
  logic                     res_valid;
  bsep_pkg::result_t        res;

  // byte limit register; zero means use the document length word
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_size <= '0;
    end else if (cfg_we) begin
      buffer_size <= cfg_wdata;
    end
  end

  assign din.ready = can_take;
  assign fire      = din.valid && can_take;

  bsep_core u_core (
    .clk            (clk),
    .rst            (rst),
    .fire           (fire),
    .data_byte      (din.data_byte),
    .start_document (din.start_document),
    .buffer_size    (buffer_size),
    .res_valid      (res_valid),
    .res            (res)
  );

  // result is loaded only for bytes that produce an event
  bsep_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (fire && res_valid),
    .res      (res),
    .can_take (can_take),
    .dout     (dout)
  );

endmodule

// ----- test/tb_bson_element_stream_parser_unit.sv -----
// Self-checking testbench for the BSON element stream parser: directed and random documents.
`timescale 1ns / 1ps

module tb_bson_element_stream_parser_unit;

  localparam int RESET_CYCLES  = 5;
  localparam int RANDOM_BYTES  = 1500;  // bytes sent in the random part
  localparam int IDLE_PCT      = 19;    // chance per cycle that a side idles
  localparam int SETTLE_CYCLES = 4;     // output register latency plus margin
  localparam int CYCLE_LIMIT   = 200000;
  localparam int REPORT_LINES  = 40;

  // Embedded document: a legal BSON type that this parser does not handle.
  localparam logic [7:0] BT_OBJECT = 8'h03;

  // Parse phases of the shadow model.
  typedef enum logic [2:0] {
    ST_LENGTH,
    ST_TYPE,
    ST_NAME,
    ST_VALUE,
    ST_LENWORD,
    ST_SUBTYPE,
    ST_PAYLOAD
  } parse_state_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  bsep_in_if  din();
  bsep_out_if dout();

  bson_element_stream_parser_unit uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .din       (din),
    .dout      (dout)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the parser state and of the buffer_size register
  // ---------------------------------------------------------------------------
  logic [31:0]  m_buffer_size;
  parse_state_t m_phase;
  logic [31:0]  m_pos;      // bytes consumed in this document
  logic [31:0]  m_limit;    // limit latched at the fourth length byte
  int unsigned  m_fcnt;     // byte index inside a multi-byte field
  logic [63:0]  m_acc;      // little-endian field assembly; subtype in [39:32]
  int unsigned  m_names;    // name characters of the current element
  logic [7:0]   m_type;
  logic [31:0]  m_left;     // payload bytes still to come
  bit           m_dead;
  bit           m_done;

  bsep_pkg::result_t predicted_events[$];
  logic [7:0] doc_bytes[$];

  int  mismatch_count;
  int  beats_checked;
  int  parsed_bytes;   // bytes that reached a live parser
  int  bytes_sent;
  int  docs_sent;
  int  kind_seen[5];
  int  cycle_count;
  bit  quiet_mode;     // no idling on either side while set

  function automatic void clear_parse();
    m_phase = ST_LENGTH;
    m_pos   = '0;
    m_limit = '0;
    m_fcnt  = 0;
    m_acc   = '0;
    m_names = 0;
    m_type  = '0;
    m_left  = '0;
    m_dead  = 1'b0;
    m_done  = 1'b0;
  endfunction

  // A read of s bytes fits if s is below the limit and ends inside it.
  function automatic bit read_fits(logic [63:0] s);
    return s < {32'd0, m_limit} && ({32'd0, m_pos} + s) <= {32'd0, m_limit};
  endfunction

  // Node type and name count always reflect the current element.
  function automatic bsep_pkg::result_t make_event(bsep_pkg::kind_t k, logic [7:0] ob,
                                                   logic [63:0] v, logic [31:0] plen,
                                                   logic [7:0] sub, logic last,
                                                   bsep_pkg::err_t e);
    bsep_pkg::result_t r;
    r.kind           = k;
    r.node_type      = m_type;
    r.name_length    = m_names[4:0];
    r.out_byte       = ob;
    r.value_bits     = v;
    r.payload_length = plen;
    r.binary_subtype = sub;
    r.last_payload   = last;
    r.error_code     = e;
    return r;
  endfunction

  function automatic bsep_pkg::result_t error_event(bsep_pkg::err_t e);
    m_dead = 1'b1;
    return make_event(bsep_pkg::KIND_ERROR, '0, '0, '0, '0, 1'b0, e);
  endfunction

  // Length word (and subtype) complete: node event, payload follows if positive.
  function automatic bsep_pkg::result_t close_length_word();
    logic [31:0] word;
    word    = m_acc[31:0];
    m_left  = ($signed(word) > 0) ? word : '0;
    m_fcnt  = 0;
    m_phase = (m_left != 0) ? ST_PAYLOAD : ST_TYPE;
    return make_event(bsep_pkg::KIND_NODE, '0, '0, word, m_acc[39:32], 1'b0,
                      bsep_pkg::ERR_NONE);
  endfunction

  // Advance the shadow parser by one byte; returns 1 when the byte yields a beat.
  function automatic bit predict_parse_event(input logic [7:0] b, input bit sd,
                                             output bsep_pkg::result_t r);
    logic [31:0] word;
    logic [31:0] lim;
    int unsigned vsize;
    bit          last;
    r = '0;
    if (sd) clear_parse();
    if (m_dead || m_done) return 0;
    parsed_bytes++;
    case (m_phase)
      ST_LENGTH: begin
        m_acc |= 64'(b) << (8 * (m_fcnt % 4));
        m_fcnt++;
        m_pos++;
        if (m_fcnt < 4) return 0;
        word    = m_acc[31:0];
        lim     = (m_buffer_size != 0) ? m_buffer_size : word;
        m_limit = lim;
        m_fcnt  = 0;
        m_acc   = '0;
        m_phase = ST_TYPE;
        if (lim <= 4) begin
          r = error_event(bsep_pkg::ERR_PAST_BUFFER);
          return 1;
        end
        // Signed compare: a limit at or above 2^31 rejects every positive word.
        if ($signed(word) > 0 && $signed(word) > $signed(lim)) begin
          r = error_event(bsep_pkg::ERR_TOO_LARGE);
          return 1;
        end
        return 0;
      end
      ST_TYPE: begin
        if (!read_fits(64'd1)) begin
          r = error_event(bsep_pkg::ERR_PAST_BUFFER);
          return 1;
        end
        m_pos++;
        m_type  = b;
        m_names = 0;
        m_acc   = '0;
        m_fcnt  = 0;
        if (b == bsep_pkg::BT_END) begin
          m_done = 1'b1;
          r = make_event(bsep_pkg::KIND_END, '0, '0, '0, '0, 1'b0, bsep_pkg::ERR_NONE);
          return 1;
        end
        if (b == bsep_pkg::BT_ERASED) begin
          r = error_event(bsep_pkg::ERR_ERASED);
          return 1;
        end
        m_phase = ST_NAME;
        return 0;
      end
      ST_NAME: begin
        if (!read_fits(64'd1)) begin
          r = error_event(bsep_pkg::ERR_PAST_BUFFER);
          return 1;
        end
        m_pos++;
        if (b == 8'h00) begin
          // Unsupported types are only flagged once the whole name is in.
          case (m_type)
            bsep_pkg::BT_DOUBLE, bsep_pkg::BT_BOOL,
            bsep_pkg::BT_INT32, bsep_pkg::BT_INT64: m_phase = ST_VALUE;
            bsep_pkg::BT_STRING, bsep_pkg::BT_BINARY: m_phase = ST_LENWORD;
            default: begin
              r = error_event(bsep_pkg::ERR_UNSUPPORTED);
              return 1;
            end
          endcase
          return 0;
        end
        m_names++;
        if (m_names >= bsep_pkg::NAME_MAX_BYTES) begin
          r = error_event(bsep_pkg::ERR_NAME_LONG);
          return 1;
        end
        r = make_event(bsep_pkg::KIND_NAME, b, '0, '0, '0, 1'b0, bsep_pkg::ERR_NONE);
        return 1;
      end
      ST_VALUE: begin
        vsize = (m_type == bsep_pkg::BT_DOUBLE || m_type == bsep_pkg::BT_INT64) ? 8 :
                (m_type == bsep_pkg::BT_INT32) ? 4 : 1;
        if (m_fcnt == 0 && !read_fits(64'(vsize))) begin
          r = error_event(bsep_pkg::ERR_PAST_BUFFER);
          return 1;
        end
        m_acc |= 64'(b) << (8 * (m_fcnt % 8));
        m_fcnt++;
        m_pos++;
        if (m_fcnt < vsize) return 0;
        m_fcnt  = 0;
        m_phase = ST_TYPE;
        if (m_type == bsep_pkg::BT_BOOL)
          r = make_event(bsep_pkg::KIND_NODE, '0, 64'(m_acc != 0), '0, '0, 1'b0,
                         bsep_pkg::ERR_NONE);
        else
          r = make_event(bsep_pkg::KIND_NODE, '0, m_acc, '0, '0, 1'b0,
                         bsep_pkg::ERR_NONE);
        return 1;
      end
      ST_LENWORD: begin
        if (m_fcnt == 0 && !read_fits(64'd4)) begin
          r = error_event(bsep_pkg::ERR_PAST_BUFFER);
          return 1;
        end
        m_acc |= 64'(b) << (8 * (m_fcnt % 4));
        m_fcnt++;
        m_pos++;
        if (m_fcnt < 4) return 0;
        m_fcnt = 0;
        if (m_type == bsep_pkg::BT_BINARY) begin
          m_phase = ST_SUBTYPE;
          return 0;
        end
        r = close_length_word();
        return 1;
      end
      ST_SUBTYPE: begin
        if (!read_fits(64'd1)) begin
          r = error_event(bsep_pkg::ERR_PAST_BUFFER);
          return 1;
        end
        m_pos++;
        m_acc |= 64'(b) << 32;
        r = close_length_word();
        return 1;
      end
      ST_PAYLOAD: begin
        // The whole payload is checked against the limit at its first byte.
        if (m_fcnt == 0) begin
          if (!read_fits({32'd0, m_left})) begin
            r = error_event(bsep_pkg::ERR_PAST_BUFFER);
            return 1;
          end
          m_fcnt = 1;
        end
        m_pos++;
        if (m_left > 0) m_left--;
        last = (m_left == 0);
        if (last) begin
          m_fcnt  = 0;
          m_phase = ST_TYPE;
        end
        r = make_event(bsep_pkg::KIND_PAYLOAD, b, '0, m_acc[31:0], m_acc[39:32], last,
                       bsep_pkg::ERR_NONE);
        return 1;
      end
      default: begin
        m_phase = ST_TYPE;
        return 0;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, timeout, result sink
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d beats still awaited",
               cycle_count, predicted_events.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // Sink stalls at random except during the quiet stretch.
  always @(posedge clk)
    dout.ready <= quiet_mode || ($urandom_range(99) >= IDLE_PCT);

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_LINES)
      $display("[%0t] MISMATCH beat %0d: %s", $realtime, beats_checked, msg);
  endtask

  task automatic check_field(input string field, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", field, got, want));
  endtask

  // Each result beat is compared with the oldest prediction.
  always @(posedge clk) begin : result_checker
    bsep_pkg::result_t want;
    if (!rst && dout.valid === 1'b1 && dout.ready === 1'b1) begin
      beats_checked++;
      if (dout.kind <= bsep_pkg::KIND_ERROR) kind_seen[dout.kind]++;
      if (predicted_events.size() == 0) begin
        report_mismatch($sformatf("unexpected beat, kind %0d", dout.kind));
      end else begin
        want = predicted_events.pop_front();
        check_field("kind",           dout.kind,           want.kind);
        check_field("node_type",      dout.node_type,      want.node_type);
        check_field("name_length",    dout.name_length,    want.name_length);
        check_field("out_byte",       dout.out_byte,       want.out_byte);
        check_field("value_bits",     dout.value_bits,     want.value_bits);
        check_field("payload_length", dout.payload_length, want.payload_length);
        check_field("binary_subtype", dout.binary_subtype, want.binary_subtype);
        check_field("last_payload",   dout.last_payload,   want.last_payload);
        check_field("error_code",     dout.error_code,     want.error_code);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Byte source and configuration
  // ---------------------------------------------------------------------------

  // Valid stays high from one beat to the next unless the source idles.
  task automatic send_byte(input logic [7:0] b, input bit sd);
    bsep_pkg::result_t ev;
    while (!quiet_mode && $urandom_range(99) < IDLE_PCT) begin
      din.valid <= 1'b0;
      @(posedge clk);
    end
    din.valid          <= 1'b1;
    din.data_byte      <= b;
    din.start_document <= sd;
    @(posedge clk);
    while (din.ready !== 1'b1) @(posedge clk);
    if (predict_parse_event(b, sd, ev)) predicted_events.push_back(ev);
    bytes_sent++;
  endtask

  // Stop sending and wait until every predicted beat has come out.
  task automatic settle_until_idle();
    din.valid <= 1'b0;
    while (predicted_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_buffer_size(input logic [31:0] v);
    settle_until_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we        <= 1'b0;
    m_buffer_size  = v;
  endtask

  // ---------------------------------------------------------------------------
  // Document building
  // ---------------------------------------------------------------------------
  function automatic void add_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) doc_bytes.push_back(w[8*i +: 8]);
  endfunction

  function automatic void add_long(input logic [63:0] w);
    for (int i = 0; i < 8; i++) doc_bytes.push_back(w[8*i +: 8]);
  endfunction

  function automatic void set_length(input logic [31:0] w);
    for (int i = 0; i < 4; i++) doc_bytes[i] = w[8*i +: 8];
  endfunction

  function automatic void begin_doc();
    doc_bytes.delete();
    add_word('0);
  endfunction

  // Type byte, then n non-NUL name characters and the terminating NUL.
  function automatic void add_head(input logic [7:0] t, input int unsigned n);
    doc_bytes.push_back(t);
    repeat (n) doc_bytes.push_back(8'($urandom_range(1, 255)));
    doc_bytes.push_back(8'h00);
  endfunction

  function automatic void seal_doc();
    doc_bytes.push_back(bsep_pkg::BT_END);
    set_length(doc_bytes.size());
  endfunction

  task automatic send_doc(input bit with_start, input int unsigned count);
    for (int unsigned i = 0; i < doc_bytes.size() && i < count; i++)
      send_byte(doc_bytes[i], with_start && i == 0);
    docs_sent++;
  endtask

  // String or binary value: length word (often small, sometimes negative or
  // huge), subtype for binary, then a handful of payload bytes.
  function automatic void add_random_payload(input bit with_subtype);
    logic [31:0] plen;
    int unsigned pick;
    int unsigned nbytes;
    pick = $urandom_range(99);
    if (pick < 70)      plen = $urandom_range(0, 8);
    else if (pick < 85) plen = 32'h8000_0000 | $urandom;
    else                plen = $urandom;
    add_word(plen);
    if (with_subtype) doc_bytes.push_back(8'($urandom));
    if ($signed(plen) <= 0) nbytes = 0;
    else if (plen <= 8)     nbytes = plen;
    else                    nbytes = $urandom_range(1, 4);
    repeat (nbytes) doc_bytes.push_back(8'($urandom));
  endfunction

  // Mostly well-formed documents with random content; some carry a bad
  // length word, a stray or erased type byte, or an overlong name.
  function automatic void build_random_doc();
    int unsigned nel;
    int unsigned pick;
    int unsigned nlen;
    begin_doc();
    nel = $urandom_range(0, 5);
    repeat (nel) begin
      pick = $urandom_range(99);
      nlen = ($urandom_range(19) == 0) ?
             $urandom_range(bsep_pkg::NAME_MAX_BYTES - 2, bsep_pkg::NAME_MAX_BYTES) :
             $urandom_range(0, 6);
      if (pick < 14) begin
        add_head(bsep_pkg::BT_DOUBLE, nlen);
        add_long({$urandom, $urandom});
      end else if (pick < 28) begin
        add_head(bsep_pkg::BT_STRING, nlen);
        add_random_payload(1'b0);
      end else if (pick < 42) begin
        add_head(bsep_pkg::BT_BINARY, nlen);
        add_random_payload(1'b1);
      end else if (pick < 58) begin
        add_head(bsep_pkg::BT_BOOL, nlen);
        doc_bytes.push_back(($urandom_range(3) == 0) ? 8'($urandom)
                                                     : 8'($urandom_range(1)));
      end else if (pick < 74) begin
        add_head(bsep_pkg::BT_INT32, nlen);
        add_word($urandom);
      end else if (pick < 90) begin
        add_head(bsep_pkg::BT_INT64, nlen);
        add_long({$urandom, $urandom});
      end else if (pick < 96) begin
        add_head(8'($urandom), nlen);
      end else begin
        add_head(bsep_pkg::BT_ERASED, nlen);
      end
    end
    seal_doc();
    pick = $urandom_range(99);
    if (pick < 6)       set_length($urandom);
    else if (pick < 12) set_length(doc_bytes.size() - $urandom_range(1, doc_bytes.size() - 1));
    else if (pick < 15) set_length($urandom_range(0, 4));
    // Junk after the end byte must be ignored.
    if ($urandom_range(9) == 0)
      repeat ($urandom_range(1, 3)) doc_bytes.push_back(8'($urandom));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Right after reset the parser takes a document without start_document.
  // One element of every supported type, extreme values in the fields.
  task automatic test_first_document_all_types();
    begin_doc();
    add_head(bsep_pkg::BT_DOUBLE, 1);
    add_long(64'hFFF0_0000_0000_0001);
    add_head(bsep_pkg::BT_STRING, 2);
    add_word(32'd3);
    doc_bytes.push_back(8'h00);
    doc_bytes.push_back(8'hff);
    doc_bytes.push_back(8'h41);
    add_head(bsep_pkg::BT_BINARY, 1);
    add_word(32'd2);
    doc_bytes.push_back(8'h80);
    doc_bytes.push_back(8'hff);
    doc_bytes.push_back(8'h00);
    add_head(bsep_pkg::BT_BOOL, 1);
    doc_bytes.push_back(8'h00);
    add_head(bsep_pkg::BT_BOOL, 0);
    doc_bytes.push_back(8'hff);
    add_head(bsep_pkg::BT_INT32, 3);
    add_word(32'h8000_0000);
    add_head(bsep_pkg::BT_INT64, 1);
    add_long(64'h7FFF_FFFF_FFFF_FFFF);
    seal_doc();
    send_doc(1'b0, doc_bytes.size());
    settle_until_idle();
  endtask

  // Length word against the limit: too small, too large, negative, and a
  // limit that reads as negative.
  task automatic test_length_word_checks();
    doc_bytes = '{8'h04, 8'h00, 8'h00, 8'h00, 8'h00};
    send_doc(1'b1, doc_bytes.size());
    doc_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    send_doc(1'b1, doc_bytes.size());
    // negative word is not "too large"; limit is the word itself
    doc_bytes = '{8'h05, 8'h00, 8'h00, 8'h80, bsep_pkg::BT_END};
    send_doc(1'b1, doc_bytes.size());
    write_buffer_size(32'd16);
    doc_bytes = '{8'h11, 8'h00, 8'h00, 8'h00, bsep_pkg::BT_END};
    send_doc(1'b1, doc_bytes.size());
    write_buffer_size(32'hFFFF_FFFF);
    doc_bytes = '{8'h05, 8'h00, 8'h00, 8'h00, bsep_pkg::BT_END};
    send_doc(1'b1, doc_bytes.size());
    doc_bytes = '{8'h00, 8'h00, 8'h00, 8'h80, bsep_pkg::BT_END};
    send_doc(1'b1, doc_bytes.size());
    write_buffer_size(32'd0);
  endtask

  // Erased flash, name length edge, unsupported type, reads past the
  // buffer, empty payloads, and a restart in the middle of a document.
  task automatic test_element_errors();
    begin_doc();
    doc_bytes.push_back(bsep_pkg::BT_ERASED);
    seal_doc();
    send_doc(1'b1, doc_bytes.size());

    begin_doc();
    add_head(bsep_pkg::BT_INT32, bsep_pkg::NAME_MAX_BYTES - 1);
    add_word(32'd1);
    add_head(bsep_pkg::BT_BOOL, bsep_pkg::NAME_MAX_BYTES);
    doc_bytes.push_back(8'h01);
    seal_doc();
    send_doc(1'b1, doc_bytes.size());

    begin_doc();
    add_head(BT_OBJECT, 2);
    add_word(32'd5);
    seal_doc();
    send_doc(1'b1, doc_bytes.size());

    // int32 value runs past a 7-byte document
    doc_bytes = '{8'h07, 8'h00, 8'h00, 8'h00, bsep_pkg::BT_INT32, 8'h61, 8'h00,
                  8'h01, 8'h02, 8'h03, 8'h04};
    send_doc(1'b1, doc_bytes.size());

    begin_doc();
    add_head(bsep_pkg::BT_STRING, 1);
    add_word(32'd0);
    add_head(bsep_pkg::BT_BINARY, 1);
    add_word(32'h8000_0000);
    doc_bytes.push_back(8'h7f);
    seal_doc();
    send_doc(1'b1, doc_bytes.size());

    begin_doc();
    add_head(bsep_pkg::BT_STRING, 1);
    add_word(32'h7FFF_FFFF);
    doc_bytes.push_back(8'h41);
    seal_doc();
    send_doc(1'b1, doc_bytes.size());

    begin_doc();
    add_head(bsep_pkg::BT_INT64, 3);
    add_long({$urandom, $urandom});
    seal_doc();
    send_doc(1'b1, 7);
    send_doc(1'b1, doc_bytes.size());
    settle_until_idle();
  endtask

  // Random documents under several buffer sizes; the last phase runs with
  // no idling on either side.
  task automatic test_random_documents();
    logic [31:0] sizes[6];
    int          share[6];
    int          goal;
    sizes = '{32'd0, 32'h7FFF_FFFF, 32'($urandom_range(5, 120)), 32'hFFFF_FFFF,
              32'($urandom), 32'd0};
    share = '{30, 15, 20, 5, 5, 25};
    for (int ph = 0; ph < 6; ph++) begin
      write_buffer_size(sizes[ph]);
      quiet_mode = (ph == 5);
      goal = bytes_sent + RANDOM_BYTES * share[ph] / 100;
      while (bytes_sent < goal) begin
        if ($urandom_range(19) == 0) begin
          // line noise, now and then with a start mark
          repeat ($urandom_range(1, 6))
            send_byte(8'($urandom), $urandom_range(3) == 0);
        end else begin
          build_random_doc();
          send_doc($urandom_range(19) != 0,
                   ($urandom_range(19) == 0) ? $urandom_range(1, doc_bytes.size())
                                             : doc_bytes.size());
        end
        if ($urandom_range(29) == 0) settle_until_idle();
      end
    end
    quiet_mode = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    din.valid          <= 1'b0;
    din.data_byte      <= '0;
    din.start_document <= 1'b0;
    m_buffer_size       = '0;
    clear_parse();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_first_document_all_types();
    test_length_word_checks();
    test_element_errors();
    test_random_documents();

    settle_until_idle();
    if (predicted_events.size() != 0)
      report_mismatch($sformatf("%0d beats never arrived", predicted_events.size()));

    $display("Covered %0d documents: %0d bytes sent, %0d parsed, %0d result beats checked",
             docs_sent, bytes_sent, parsed_bytes, beats_checked);
    $display("Beats by kind: name %0d, node %0d, payload %0d, end %0d, error %0d",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4]);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
